// ===== rtl/isk_pkg.sv =====
// shared constants and types for the indirect sorted key lookup unit
package isk_pkg;

    localparam int MAX_DOCS = 1024;
    localparam int KEY_BITS = 64;
    localparam int NODE_W   = $clog2(MAX_DOCS);
    localparam int CNT_W    = NODE_W + 1;

    localparam int OPCODE_W    = 2;
    localparam int S_FIELDS_W  = NODE_W + KEY_BITS + NODE_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((NODE_W + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_WR_ORDER = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WR_KEY   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP   = 2'd2;

    localparam logic [CNT_W-1:0] MAX_DOCS_CNT = CNT_W'(MAX_DOCS);

    typedef struct packed {
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [NODE_W-1:0] wr_data;
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
    } order_port_t;

    typedef struct packed {
        logic                wr_en;
        logic [NODE_W-1:0]   wr_addr;
        logic [KEY_BITS-1:0] wr_data;
        logic                rd_en;
        logic [NODE_W-1:0]   rd_addr;
    } key_port_t;

endpackage

// ===== rtl/indirect_sorted_key_lookup_unit.sv =====
// top level of the indirect sorted key lookup unit
//
// s_ channel: one transfer per item. s_tuser carries the opcode (write ordering entry,
// write key entry, lookup). Writes go straight into the tables and produce nothing on m_.
// A lookup binary-searches the first doc_count sorted positions; each probe reads the
// ordering table, then the key table at the node id found there.
// m_ channel: one transfer per lookup, m_tuser = found, m_tdata = node id (zero on a miss).
// cfg_ channel: writes doc_count, always ready; write it only while the unit is idle.
// Sequencing: a write goes into its table as it is accepted. A lookup runs ST_ORD then
// ST_CMP for each probe (the two dependent memory reads, each registered), then ST_RES;
// at most 11 probes for 1024 entries; s_tready is high only between items.
// The result sits in an output register: a stalled receiver holds it while the next
// item is already accepted; a further result waits until that register is taken.
// Reset clears the sequencer, doc_count and the output valid; the tables keep their
// contents and are undefined until written.
module indirect_sorted_key_lookup_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [isk_pkg::S_TDATA_W-1:0]  s_tdata,   // slot, search_key, entry_node, zero pad
    input  logic [isk_pkg::OPCODE_W-1:0]   s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [isk_pkg::M_TDATA_W-1:0]  m_tdata,   // result_node, zero pad
    output logic [0:0]                     m_tuser,   // found
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [isk_pkg::CNT_W-1:0]      cfg_data
);
    import isk_pkg::*;

    order_port_t         order_port;
    key_port_t           key_port;
    logic [NODE_W-1:0]   order_rd_data;
    logic [KEY_BITS-1:0] key_rd_data;

    isk_order_ram u_order_ram (
        .aclk    (aclk),
        .port    (order_port),
        .rd_data (order_rd_data)
    );

    isk_key_ram u_key_ram (
        .aclk    (aclk),
        .port    (key_port),
        .rd_data (key_rd_data)
    );

    isk_search_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .order_port    (order_port),
        .order_rd_data (order_rd_data),
        .key_port      (key_port),
        .key_rd_data   (key_rd_data)
    );

endmodule

// ===== rtl/isk_order_ram.sv =====
// ordering table: sorted position to node id, one write and one registered read port
module isk_order_ram (
    input  logic                        aclk,
    input  isk_pkg::order_port_t        port,
    output logic [isk_pkg::NODE_W-1:0]  rd_data
);
    import isk_pkg::*;

    logic [NODE_W-1:0] mem [MAX_DOCS];
    logic [NODE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (port.wr_en) begin
            mem[port.wr_addr] <= port.wr_data;
        end
        if (port.rd_en) begin
            rd_data_reg <= mem[port.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/isk_key_ram.sv =====
// key table: node id to key, one write and one registered read port
module isk_key_ram (
    input  logic                          aclk,
    input  isk_pkg::key_port_t            port,
    output logic [isk_pkg::KEY_BITS-1:0]  rd_data
);
    import isk_pkg::*;

    logic [KEY_BITS-1:0] mem [MAX_DOCS];
    logic [KEY_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (port.wr_en) begin
            mem[port.wr_addr] <= port.wr_data;
        end
        if (port.rd_en) begin
            rd_data_reg <= mem[port.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/isk_search_ctrl.sv =====
// search sequencer: table writes, binary search through both tables, output register
module isk_search_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [isk_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [isk_pkg::OPCODE_W-1:0]   s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [isk_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                     m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [isk_pkg::CNT_W-1:0]      cfg_data,
    output isk_pkg::order_port_t           order_port,
    input  logic [isk_pkg::NODE_W-1:0]     order_rd_data,
    output isk_pkg::key_port_t             key_port,
    input  logic [isk_pkg::KEY_BITS-1:0]   key_rd_data
);
    import isk_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ORD  = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_RES  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    doc_count_reg, doc_count_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [NODE_W-1:0]   mid_reg, mid_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]    lt_lo_reg, lt_lo_next;
    logic [NODE_W-1:0]   lt_mid_reg, lt_mid_next;
    logic                lt_go_reg, lt_go_next;
    logic [NODE_W-1:0]   gt_mid_reg, gt_mid_next;
    logic                gt_go_reg, gt_go_next;
    logic                res_found_reg, res_found_next;
    logic [NODE_W-1:0]   res_node_reg, res_node_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                m_found_reg, m_found_next;
    logic [NODE_W-1:0]   m_node_reg, m_node_next;

    logic [NODE_W-1:0]   in_slot;
    logic [KEY_BITS-1:0] in_key;
    logic [NODE_W-1:0]   in_node;
    logic                s_xfer;
    logic                out_free;
    logic [CNT_W-1:0]    hi_init;
    logic [CNT_W-1:0]    mid_ext;
    logic [CNT_W-1:0]    mid_plus1;
    logic [CNT_W-1:0]    lt_mid_full;
    logic [CNT_W-1:0]    gt_mid_full;

    assign in_slot = s_tdata[NODE_W-1:0];
    assign in_key  = s_tdata[NODE_W +: KEY_BITS];
    assign in_node = s_tdata[NODE_W+KEY_BITS +: NODE_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // counts above the table depth search the whole table
    assign hi_init = (doc_count_reg > MAX_DOCS_CNT) ? MAX_DOCS_CNT : doc_count_reg;

    // both possible next probes are prepared while the key read is in flight
    assign mid_ext     = {1'b0, mid_reg};
    assign mid_plus1   = mid_ext + CNT_W'(1);
    assign lt_mid_full = mid_plus1 + ((hi_reg - mid_plus1) >> 1);
    assign gt_mid_full = lo_reg + ((mid_ext - lo_reg) >> 1);

    always_comb begin
        state_next     = state_reg;
        doc_count_next = doc_count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        lt_lo_next     = lt_lo_reg;
        lt_mid_next    = lt_mid_reg;
        lt_go_next     = lt_go_reg;
        gt_mid_next    = gt_mid_reg;
        gt_go_next     = gt_go_reg;
        res_found_next = res_found_reg;
        res_node_next  = res_node_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_found_next   = m_found_reg;
        m_node_next    = m_node_reg;

        order_port.wr_en   = 1'b0;
        order_port.wr_addr = in_slot;
        order_port.wr_data = in_node;
        order_port.rd_en   = 1'b0;
        order_port.rd_addr = mid_reg;
        key_port.wr_en     = 1'b0;
        key_port.wr_addr   = in_slot;
        key_port.wr_data   = in_key;
        key_port.rd_en     = 1'b0;
        key_port.rd_addr   = order_rd_data;

        if (cfg_valid && cfg_ready) begin
            doc_count_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (s_tuser)
                        OP_WR_ORDER: begin
                            order_port.wr_en = 1'b1;
                        end
                        OP_WR_KEY: begin
                            key_port.wr_en = 1'b1;
                        end
                        OP_LOOKUP: begin
                            key_next = in_key;
                            lo_next  = '0;
                            hi_next  = hi_init;
                            mid_next = hi_init[CNT_W-1:1];
                            if (hi_init == '0) begin
                                res_found_next = 1'b0;
                                res_node_next  = '0;
                                state_next     = ST_RES;
                            end else begin
                                order_port.rd_en   = 1'b1;
                                order_port.rd_addr = hi_init[CNT_W-1:1];
                                state_next         = ST_ORD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ORD: begin
                key_port.rd_en = 1'b1;
                lt_lo_next     = mid_plus1;
                lt_mid_next    = lt_mid_full[NODE_W-1:0];
                lt_go_next     = mid_plus1 < hi_reg;
                gt_mid_next    = gt_mid_full[NODE_W-1:0];
                gt_go_next     = lo_reg < mid_ext;
                state_next     = ST_CMP;
            end
            ST_CMP: begin
                if (key_rd_data == key_reg) begin
                    res_found_next = 1'b1;
                    res_node_next  = order_rd_data;
                    state_next     = ST_RES;
                end else if (key_rd_data < key_reg) begin
                    lo_next  = lt_lo_reg;
                    mid_next = lt_mid_reg;
                    if (lt_go_reg) begin
                        order_port.rd_en   = 1'b1;
                        order_port.rd_addr = lt_mid_reg;
                        state_next         = ST_ORD;
                    end else begin
                        res_found_next = 1'b0;
                        res_node_next  = '0;
                        state_next     = ST_RES;
                    end
                end else begin
                    hi_next  = mid_ext;
                    mid_next = gt_mid_reg;
                    if (gt_go_reg) begin
                        order_port.rd_en   = 1'b1;
                        order_port.rd_addr = gt_mid_reg;
                        state_next         = ST_ORD;
                    end else begin
                        res_found_next = 1'b0;
                        res_node_next  = '0;
                        state_next     = ST_RES;
                    end
                end
            end
            ST_RES: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = res_found_reg;
                    m_node_next   = res_node_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            doc_count_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            doc_count_reg <= doc_count_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        lt_lo_reg     <= lt_lo_next;
        lt_mid_reg    <= lt_mid_next;
        lt_go_reg     <= lt_go_next;
        gt_mid_reg    <= gt_mid_next;
        gt_go_reg     <= gt_go_next;
        res_found_reg <= res_found_next;
        res_node_reg  <= res_node_next;
        m_found_reg   <= m_found_next;
        m_node_reg    <= m_node_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = M_TDATA_W'(m_node_reg);
    assign m_tuser[0] = m_found_reg;

    // a probe is only in flight while the search window is non-empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ORD) |-> (lo_reg < hi_reg) && (hi_reg <= MAX_DOCS_CNT))
        else $error("search window empty or too large during probe");

    // table writes never overlap a running search
    assert property (@(posedge aclk) disable iff (!aresetn)
        (order_port.wr_en || key_port.wr_en) |-> (state_reg == ST_IDLE))
        else $error("table write outside idle");

    // order reads are issued only at lookup start or after a compare
    assert property (@(posedge aclk) disable iff (!aresetn)
        order_port.rd_en |=> (state_reg == ST_ORD))
        else $error("order read not followed by key read step");

    // a miss always reports node zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss with nonzero node");

    // a pending result is never overwritten before it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output register overwritten while stalled");

endmodule
